@@ rtl/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Field widths fixed by the poll and result formats.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RAW_W   = 4;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] LONG1_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] LONG2_RST    = 16'd2000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG1    = 2'd1,
    CFG_LONG2    = 2'd2
  } cfg_idx_e;

  // Current register contents, shared by all button cells.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long1_ms;
    logic [CFG_W-1:0] long2_ms;
  } cfg_t;

  // Per-button outcome of one poll.
  typedef struct packed {
    logic short_ev;
    logic long1_ev;
    logic long2_ev;
    logic held;
  } btn_evt_t;

endpackage

@@ rtl/bdpc_if.sv @@
// ----------------------------------------------------------------------------
// bdpc interfaces
// Valid/ready channels for polls, results and register writes.
// ----------------------------------------------------------------------------

// Poll channel: current time and raw button levels.
interface bdpc_poll_if;
  logic                         valid;
  logic                         ready;
  logic [bdpc_pkg::TIME_W-1:0]  now_ms;
  logic [bdpc_pkg::RAW_W-1:0]   raw_pressed;

  modport source (output valid, output now_ms, output raw_pressed, input ready);
  modport sink   (input valid, input now_ms, input raw_pressed, output ready);
endinterface

// Result channel: event masks and debounced levels.
interface bdpc_result_if;
  logic                       valid;
  logic                       ready;
  logic [bdpc_pkg::RAW_W-1:0] short_events;
  logic [bdpc_pkg::RAW_W-1:0] long1_events;
  logic [bdpc_pkg::RAW_W-1:0] long2_events;
  logic [bdpc_pkg::RAW_W-1:0] held_mask;

  modport source (output valid, output short_events, output long1_events,
                  output long2_events, output held_mask, input ready);
  modport sink   (input valid, input short_events, input long1_events,
                  input long2_events, input held_mask, output ready);
endinterface

// Register write channel.
interface bdpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdpc_pkg::CFG_IDX_W-1:0] index;
  logic [bdpc_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bdpc_cfg.sv @@
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration registers: debounce time and the two long-press thresholds.
// ----------------------------------------------------------------------------
module bdpc_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bdpc_cfg_if.sink             cfg_i,
  output bdpc_pkg::cfg_t       cfg_o
);

  bdpc_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= bdpc_pkg::DEBOUNCE_RST;
      cfg_q.long1_ms    <= bdpc_pkg::LONG1_RST;
      cfg_q.long2_ms    <= bdpc_pkg::LONG2_RST;
    end else if (cfg_i.valid) begin
      unique case (bdpc_pkg::cfg_idx_e'(cfg_i.index))
        bdpc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_i.data;
        bdpc_pkg::CFG_LONG1:    cfg_q.long1_ms    <= cfg_i.data;
        bdpc_pkg::CFG_LONG2:    cfg_q.long2_ms    <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bdpc_btn.sv @@
// ----------------------------------------------------------------------------
// bdpc_btn
// One button: debounce state, press timing and one-shot long-press flags.
// ----------------------------------------------------------------------------
module bdpc_btn (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [bdpc_pkg::TIME_W-1:0]        now_i,
  input  logic                               raw_i,
  input  bdpc_pkg::cfg_t                     cfg_i,
  output bdpc_pkg::btn_evt_t                 evt_o
);

  localparam int unsigned PadW = bdpc_pkg::TIME_W - bdpc_pkg::CFG_W;

  logic                        raw_last_q, raw_last_d;
  logic                        stable_q, stable_d;
  logic                        l1_fired_q, l1_fired_d;
  logic                        l2_fired_q, l2_fired_d;
  logic [bdpc_pkg::TIME_W-1:0] bounce_start_q, bounce_start_d;
  logic [bdpc_pkg::TIME_W-1:0] press_start_q, press_start_d;

  logic                        raw_chg;
  logic                        accept;
  logic                        press_acc;
  logic                        release_acc;
  logic [bdpc_pkg::TIME_W-1:0] bounce_diff;
  logic [bdpc_pkg::TIME_W-1:0] press_diff;
  logic [bdpc_pkg::TIME_W-1:0] hold;
  logic [bdpc_pkg::TIME_W-1:0] debounce_w, long1_w, long2_w;
  logic                        l1_armed, l2_armed;
  logic                        long1_ev, long2_ev;

  assign debounce_w = {{PadW{1'b0}}, cfg_i.debounce_ms};
  assign long1_w    = {{PadW{1'b0}}, cfg_i.long1_ms};
  assign long2_w    = {{PadW{1'b0}}, cfg_i.long2_ms};

  // Debounce: a raw change restarts the timer, so its elapsed time is zero.
  assign raw_chg     = raw_i != raw_last_q;
  assign bounce_diff = now_i - bounce_start_q;
  assign accept      = !raw_chg && (bounce_diff > debounce_w) && (raw_i != stable_q);
  assign press_acc   = accept && raw_i;
  assign release_acc = accept && !raw_i;

  // Hold time; a press taken on this poll starts at zero.
  assign press_diff = now_i - press_start_q;
  assign hold       = press_acc ? '0 : press_diff;
  assign l1_armed   = press_acc || !l1_fired_q;
  assign l2_armed   = press_acc || !l2_fired_q;

  assign stable_d = accept ? raw_i : stable_q;
  assign long1_ev = stable_d && l1_armed && (hold >= long1_w);
  assign long2_ev = stable_d && l2_armed && (hold >= long2_w);

  assign raw_last_d     = raw_i;
  assign bounce_start_d = raw_chg ? now_i : bounce_start_q;
  assign press_start_d  = press_acc ? now_i : press_start_q;
  assign l1_fired_d     = !l1_armed || long1_ev;
  assign l2_fired_d     = !l2_armed || long2_ev;

  // Outcome of the poll currently presented.
  assign evt_o.short_ev = release_acc && (press_diff < long1_w);
  assign evt_o.long1_ev = long1_ev;
  assign evt_o.long2_ev = long2_ev;
  assign evt_o.held     = stable_d;

  // Button state advances once per processed poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q     <= 1'b0;
      stable_q       <= 1'b0;
      l1_fired_q     <= 1'b0;
      l2_fired_q     <= 1'b0;
      bounce_start_q <= '0;
      press_start_q  <= '0;
    end else if (step_i) begin
      raw_last_q     <= raw_last_d;
      stable_q       <= stable_d;
      l1_fired_q     <= l1_fired_d;
      l2_fired_q     <= l2_fired_d;
      bounce_start_q <= bounce_start_d;
      press_start_q  <= press_start_d;
    end
  end

endmodule

@@ rtl/button_debounce_press_classifier_top.sv @@
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces a group of buttons and classifies short and long presses.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on poll_i carries the current millisecond time and the raw
// pressed level of four buttons. For every poll exactly one beat leaves on
// result_o with the short, long1 and long2 event masks and the debounced
// held mask. Registers are written on cfg_i (index 0 debounce, 1 long1,
// 2 long2, 16-bit data); cfg_i is always ready, and a write is meant to
// happen only while no poll is in flight.
// A poll is captured in the input register at acceptance; its result then
// moves into the result register and leaves from there on result_o.
// Throughput is one poll per cycle while result_o is not stalled: the input
// and result registers stream, and every button cell updates per poll.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and poll_i.ready drops until the result is taken.
// Reset clears all button state, both valid flags and loads the register
// defaults (30, 1000, 2000 ms).
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bdpc_poll_if.sink      poll_i,
  bdpc_result_if.source  result_o,
  bdpc_cfg_if.sink       cfg_i
);

  localparam int unsigned RawW = bdpc_pkg::RAW_W;

  logic                        poll_valid_q;
  logic [bdpc_pkg::TIME_W-1:0] now_q;
  logic [RawW-1:0]             raw_q;
  logic                        res_valid_q;
  logic [RawW-1:0]             short_q, long1_q, long2_q, held_q;
  logic [RawW-1:0]             short_d, long1_d, long2_d, held_d;
  logic                        advance;

  bdpc_pkg::cfg_t              cfg;
  bdpc_pkg::btn_evt_t          evt [NUM_BUTTONS];

  // Register file.
  bdpc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // A poll moves into the result register when that register is free or draining.
  assign advance      = poll_valid_q && (!res_valid_q || result_o.ready);
  assign poll_i.ready = !poll_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      poll_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      now_q <= poll_i.now_ms;
      raw_q <= poll_i.raw_pressed;
    end
  end

  // Button cells; buttons past the raw field always read released.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    logic raw_b;
    if (b < RawW) begin : g_raw
      assign raw_b = raw_q[b];
    end else begin : g_zero
      assign raw_b = 1'b0;
    end

    bdpc_btn u_btn (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (advance),
      .now_i  (now_q),
      .raw_i  (raw_b),
      .cfg_i  (cfg),
      .evt_o  (evt[b])
    );
  end

  // Gather the visible buttons into the result masks.
  for (genvar j = 0; j < RawW; j++) begin : g_mask
    if (j < NUM_BUTTONS) begin : g_live
      assign short_d[j] = evt[j].short_ev;
      assign long1_d[j] = evt[j].long1_ev;
      assign long2_d[j] = evt[j].long2_ev;
      assign held_d[j]  = evt[j].held;
    end else begin : g_none
      assign short_d[j] = 1'b0;
      assign long1_d[j] = 1'b0;
      assign long2_d[j] = 1'b0;
      assign held_d[j]  = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      short_q <= short_d;
      long1_q <= long1_d;
      long2_q <= long2_d;
      held_q  <= held_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.short_events = short_q;
  assign result_o.long1_events = long1_q;
  assign result_o.long2_events = long2_q;
  assign result_o.held_mask    = held_q;

`ifndef SYNTHESIS
  // A short event comes from a release, so it never pairs with a long event.
  a_short_excl_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((short_q & (long1_q | long2_q)) == '0))
    else $error("short and long event on the same button");

  // A released button cannot still be held.
  a_short_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((short_q & held_q) == '0))
    else $error("short event on a held button");

  // A processed poll always lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("processed poll lost");

  // A waiting poll keeps its time stamp until it is processed.
  a_poll_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (poll_valid_q && !advance) |=> (poll_valid_q && $stable(now_q)))
    else $error("waiting poll changed");
`endif

endmodule
